[design/ccss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage cell span sweep package
// Shared constants, command and register codes, and the types that travel
// between the run preparation stage, the pending span stage and the top level.
// ----------------------------------------------------------------------------
package ccss_pkg;

	localparam int SUBPIXEL_BITS = 8;
	localparam int ONE2_SHIFT    = SUBPIXEL_BITS + 1;
	localparam int AREA_SHIFT    = 2 * SUBPIXEL_BITS - 7;
	localparam int COVER_W       = 24;
	localparam int AREA_W        =
		((COVER_W + ONE2_SHIFT > 32) ? COVER_W + ONE2_SHIFT : 32) + 1;

	localparam logic [1:0] CMD_CELL    = 2'd0;
	localparam logic [1:0] CMD_ROW_END = 2'd1;
	localparam logic [1:0] CMD_FLUSH   = 2'd2;

	localparam logic [2:0] REG_EVEN_ODD       = 3'd0;
	localparam logic [2:0] REG_ANTI_ALIAS     = 3'd1;
	localparam logic [2:0] REG_CLIP_WIDTH     = 3'd2;
	localparam logic [2:0] REG_CLIP_HEIGHT    = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X       = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y       = 3'd5;
	localparam logic [2:0] REG_ROW_CELL_COUNT = 3'd6;

	typedef struct packed {
		logic        even_odd;
		logic        anti_alias;
		logic [14:0] clip_width;
		logic [14:0] clip_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [14:0] row_cell_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [14:0] row;
		logic [15:0] cell_x;
		logic [15:0] cell_cover;
		logic [31:0] cell_area;
	} item_t;

	// One clipped run, ready for the merge against the pending span.
	typedef struct packed {
		logic        valid;
		logic [15:0] x;
		logic [14:0] x0;
		logic [14:0] y;
		logic [7:0]  cov;
		logic [15:0] mlen;
		logic        nlen_ok;
		logic [15:0] nlen;
	} run_t;

	typedef struct packed {
		run_t run_a;
		run_t run_b;
		logic flush;
	} stage_t;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
		logic [15:0] len;
		logic [7:0]  cov;
	} span_t;

	typedef struct packed {
		logic  emit_a;
		logic  emit_b;
		span_t span_a;
		span_t span_b;
	} result_t;

endpackage

[design/coverage_cell_span_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage cell span sweep
// Turns row-sorted coverage cells into merged, clipped horizontal spans.
// ----------------------------------------------------------------------------
// Requests enter on the item channel (item_valid, item_stall) and spans leave
// on the span channel (span_valid, span_stall); last_of_item marks the final
// span caused by one request. The user must write registers through cfg_valid
// and cfg_ready with cfg_index and cfg_data only while the block is idle;
// the block does not enforce this. A request is registered at acceptance;
// its runs are prepared from that register and registered again, then merged
// against the pending span and written to the span queue. A span stays
// pending until a later run starts a new span or a flush request pushes it.
// A request may be accepted every cycle while item_stall is low; one request
// produces up to two spans through the single output port, so the output
// port limits the sustained rate when every cell splits the pending span.
// A four-entry span queue absorbs bursts. When the receiver stalls, the
// queue fills and item_stall rises. Reset clears the queue, the pending
// span, the row cover and next column, and loads the register reset values.
// ----------------------------------------------------------------------------
module coverage_cell_span_sweep (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [14:0] row,
	input  logic [15:0] cell_x,
	input  logic [15:0] cell_cover,
	input  logic [31:0] cell_area,
	output logic        span_valid,
	input  logic        span_stall,
	output logic [14:0] span_x,
	output logic [14:0] span_y,
	output logic [15:0] span_len,
	output logic [7:0]  span_coverage,
	output logic        last_of_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ccss_pkg::*;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	typedef struct packed {
		span_t span;
		logic  last;
	} out_t;

	cfg_t             cfg_q;
	item_t            s1_q;
	logic             s1_valid_q;
	stage_t           stage;
	stage_t           s2_q;
	logic             s2_valid_q;
	result_t          res;
	out_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             s1_move;
	logic             s2_ready;
	logic             fire;
	logic             pop;
	logic [1:0]       n_push;
	out_t             first;
	out_t             second;

	assign cfg_ready = 1'b1;

	assign fire     = s2_valid_q && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s2_ready = !s2_valid_q || fire;
	assign s1_move  = s1_valid_q && s2_ready;
	assign item_stall = s1_valid_q && !s2_ready;
	assign accept   = item_valid && !item_stall;

	assign span_valid = (count_q != '0);
	assign pop        = span_valid && !span_stall;

	assign span_x        = fifo_q[rd_ptr_q].span.x;
	assign span_y        = fifo_q[rd_ptr_q].span.y;
	assign span_len      = fifo_q[rd_ptr_q].span.len;
	assign span_coverage = fifo_q[rd_ptr_q].span.cov;
	assign last_of_item  = fifo_q[rd_ptr_q].last;

	always_comb begin
		n_push      = {1'b0, res.emit_a} + {1'b0, res.emit_b};
		first.span  = res.emit_a ? res.span_a : res.span_b;
		first.last  = !(res.emit_a && res.emit_b);
		second.span = res.span_b;
		second.last = 1'b1;
	end

	ccss_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_move),
		.item    (s1_q),
		.cfg     (cfg_q),
		.stage   (stage)
	);

	ccss_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.stage  (s2_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{even_odd: 1'b0, anti_alias: 1'b1, default: '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EVEN_ODD:       cfg_q.even_odd       <= cfg_data[0];
				REG_ANTI_ALIAS:     cfg_q.anti_alias     <= cfg_data[0];
				REG_CLIP_WIDTH:     cfg_q.clip_width     <= cfg_data[14:0];
				REG_CLIP_HEIGHT:    cfg_q.clip_height    <= cfg_data[14:0];
				REG_ORIGIN_X:       cfg_q.origin_x       <= cfg_data;
				REG_ORIGIN_Y:       cfg_q.origin_y       <= cfg_data;
				REG_ROW_CELL_COUNT: cfg_q.row_cell_count <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (fire) begin
				s2_valid_q <= 1'b0;
			end
			if (fire) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(n_push));
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + (fire ? CNT_W'(n_push) : CNT_W'(0)) -
				CNT_W'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.cmd        <= cmd;
			s1_q.row        <= row;
			s1_q.cell_x     <= cell_x;
			s1_q.cell_cover <= cell_cover;
			s1_q.cell_area  <= cell_area;
		end
		if (s1_move) begin
			s2_q <= stage;
		end
		if (fire && (n_push != 2'd0)) begin
			fifo_q[wr_ptr_q] <= first;
		end
		if (fire && (n_push == 2'd2)) begin
			fifo_q[PTR_W'(wr_ptr_q + 1'b1)] <= second;
		end
	end

endmodule

[design/ccss_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run preparation
// Holds the row cover and next free column, and turns one item into a gap
// run and a cell run with coverage, origin offset and viewport clipping.
// ----------------------------------------------------------------------------
module ccss_prep (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ccss_pkg::item_t  item,
	input  ccss_pkg::cfg_t   cfg,
	output ccss_pkg::stage_t stage
);
	import ccss_pkg::*;

	logic [COVER_W-1:0]       cover_q;
	logic [15:0]              next_x_q;
	logic [COVER_W-1:0]       cover_new;
	logic signed [16:0]       cx;
	logic signed [16:0]       nx;
	logic signed [AREA_W-1:0] area_gap;
	logic signed [AREA_W-1:0] area_cell;
	logic signed [17:0]       count_a;
	logic                     is_cell;
	logic                     is_end;
	logic                     cond_a;
	logic                     cond_b;

	function automatic run_t eval_run(
		input logic                     cond,
		input logic signed [16:0]       x,
		input logic signed [AREA_W-1:0] area,
		input logic signed [17:0]       count,
		input logic [14:0]              row,
		input cfg_t                     c
	);
		logic signed [17:0]       xo;
		logic signed [16:0]       yo;
		logic                     y_ok;
		logic signed [AREA_W-1:0] sh;
		logic signed [AREA_W-1:0] mag;
		logic [8:0]               m9;
		logic [7:0]               cv;
		logic                     covered;
		logic signed [15:0]       xc;
		logic signed [19:0]       xe;
		logic signed [19:0]       cw;
		logic signed [19:0]       lm;
		logic signed [19:0]       nl;
		run_t                     r;
		xo = 18'(x) + 18'($signed(c.origin_x));
		yo = $signed({2'b00, row}) + 17'($signed(c.origin_y));
		y_ok = !yo[16] && (yo[15:0] < {1'b0, c.clip_height});
		sh = area >>> AREA_SHIFT;
		mag = sh[AREA_W-1] ? -sh : sh;
		m9 = mag[8:0];
		if (c.even_odd) begin
			if (m9 > 9'd256) begin
				cv = 8'(10'd512 - {1'b0, m9});
			end else if (m9 == 9'd256) begin
				cv = 8'hFF;
			end else begin
				cv = m9[7:0];
			end
		end else if (|mag[AREA_W-1:8]) begin
			cv = 8'hFF;
		end else begin
			cv = mag[7:0];
		end
		covered = (cv != 8'd0);
		if (!c.anti_alias) begin
			cv = 8'hFF;
		end
		if (xo >= 18'sd32767) begin
			xc = 16'sh7FFF;
		end else begin
			xc = xo[15:0];
		end
		xe = 20'(xc) + 20'(count);
		cw = $signed({5'b00000, c.clip_width});
		lm = (xe >= cw) ? cw - 20'(xc) : 20'(count);
		nl = lm + (xc[15] ? 20'(xc) : 20'sd0);
		r.valid   = cond && y_ok && covered;
		r.x       = xc;
		r.x0      = xc[15] ? 15'd0 : xc[14:0];
		r.y       = yo[14:0];
		r.cov     = cv;
		r.mlen    = lm[15:0];
		r.nlen_ok = !nl[19] && (nl != 20'sd0);
		r.nlen    = nl[15:0];
		return r;
	endfunction

	always_comb begin
		is_cell   = (item.cmd == CMD_CELL);
		is_end    = (item.cmd == CMD_ROW_END);
		cx        = item.cell_x[15] ? -17'sd1 : $signed({1'b0, item.cell_x});
		nx        = $signed({1'b0, next_x_q});
		cover_new = COVER_W'(cover_q + COVER_W'($signed(item.cell_cover)));
		area_gap  = AREA_W'($signed(cover_q)) <<< ONE2_SHIFT;
		area_cell = (AREA_W'($signed(cover_new)) <<< ONE2_SHIFT) -
			AREA_W'($signed(item.cell_area));
		count_a   = is_cell ? 18'(cx) - 18'(nx) :
			$signed({3'b000, cfg.row_cell_count}) - 18'(nx);
		cond_a    = ((is_cell && (cx > nx)) || is_end) && (cover_q != '0);
		cond_b    = is_cell && (area_cell != '0) && !item.cell_x[15];
		stage.run_a = eval_run(cond_a, nx, area_gap, count_a, item.row, cfg);
		stage.run_b = eval_run(cond_b, cx, area_cell, 18'sd1, item.row, cfg);
		stage.flush = (item.cmd == CMD_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cover_q  <= '0;
			next_x_q <= '0;
		end else if (advance) begin
			unique case (item.cmd)
				CMD_CELL: begin
					cover_q  <= cover_new;
					next_x_q <= 16'(cx + 17'sd1);
				end
				CMD_ROW_END: begin
					cover_q  <= '0;
					next_x_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/ccss_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending span stage
// Holds the pending span, merges runs that continue it and hands out the
// spans that a new run or a band flush pushes out.
// ----------------------------------------------------------------------------
module ccss_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ccss_pkg::stage_t  stage,
	output ccss_pkg::result_t res
);
	import ccss_pkg::*;

	typedef struct packed {
		logic  valid;
		span_t span;
	} pend_t;

	typedef struct packed {
		logic  emit;
		span_t span;
		pend_t pend;
	} step_t;

	pend_t pend_q;
	pend_t pend_next;
	step_t sa;
	step_t sb;

	function automatic step_t apply(input pend_t p, input run_t r);
		logic  merge;
		step_t s;
		merge = r.valid && p.valid && (p.span.y == r.y) && !r.x[15] &&
			(({2'b00, p.span.x} + {1'b0, p.span.len}) == {2'b00, r.x[14:0]}) &&
			(p.span.cov == r.cov);
		s.emit = 1'b0;
		s.span = p.span;
		s.pend = p;
		if (merge) begin
			s.pend.span.len = p.span.len + r.mlen;
		end else if (r.valid && r.nlen_ok) begin
			s.emit          = p.valid;
			s.pend.valid    = 1'b1;
			s.pend.span.x   = r.x0;
			s.pend.span.y   = r.y;
			s.pend.span.len = r.nlen;
			s.pend.span.cov = r.cov;
		end
		return s;
	endfunction

	always_comb begin
		sa = apply(pend_q, stage.run_a);
		sb = apply(sa.pend, stage.run_b);
		if (stage.flush) begin
			res.emit_a = pend_q.valid;
			res.span_a = pend_q.span;
			res.emit_b = 1'b0;
			res.span_b = pend_q.span;
			pend_next  = '0;
		end else begin
			res.emit_a = sa.emit;
			res.span_a = sa.span;
			res.emit_b = sb.emit;
			res.span_b = sb.span;
			pend_next  = sb.pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (fire) begin
			pend_q <= pend_next;
		end
	end

endmodule
